>>> rtl/tfi_pkg.sv
// Shared types, constants and step tables of the transfinite interpolation block.
package tfi_pkg;

   localparam int IDX_W          = 5;
   localparam int COORD_W        = 32;
   localparam int SIZE_W         = 6;
   localparam int CSR_ADDR_W     = 2;
   localparam int REQ_DATA_W     = 112;
   localparam int RSP_DATA_W     = 96;
   localparam int MAX_N_DEF      = 32;
   localparam int COORD_BITS_DEF = 32;
   localparam int N_TERMS        = 26;
   localparam int WGT_W          = 16;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERR   = 1'b1;

   // weight file slots: face weights in 0 to 5, edge products in 6 to 17, corner products in 18 to 25
   localparam logic [4:0] W_A0    = 5'd0;
   localparam logic [4:0] W_A1    = 5'd1;
   localparam logic [4:0] W_B0    = 5'd2;
   localparam logic [4:0] W_B1    = 5'd3;
   localparam logic [4:0] W_C0    = 5'd4;
   localparam logic [4:0] W_C1    = 5'd5;
   localparam logic [4:0] W_A0B0  = 5'd6;
   localparam logic [4:0] W_A0B1  = 5'd7;
   localparam logic [4:0] W_A1B0  = 5'd8;
   localparam logic [4:0] W_A1B1  = 5'd9;
   localparam logic [4:0] W_FIRST_PROD = 5'd6;
   localparam logic [4:0] W_LAST  = 5'd25;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_IDX  = 2'd1,
      SEL_END  = 2'd2
   } axsel_type;

   typedef struct packed {
      axsel_type sx;
      axsel_type sy;
      axsel_type sz;
      logic      neg;
   } term_type;

   typedef struct packed {
      logic [4:0] p;
      logic [4:0] q;
   } wop_type;

   // term t uses weight slot t
   function automatic term_type term_info(input logic [4:0] t);
      term_type r;
      r = '{SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0};
      case (t)
         5'd0:  r = '{SEL_ZERO, SEL_IDX,  SEL_IDX,  1'b0};
         5'd1:  r = '{SEL_END,  SEL_IDX,  SEL_IDX,  1'b0};
         5'd2:  r = '{SEL_IDX,  SEL_ZERO, SEL_IDX,  1'b0};
         5'd3:  r = '{SEL_IDX,  SEL_END,  SEL_IDX,  1'b0};
         5'd4:  r = '{SEL_IDX,  SEL_IDX,  SEL_ZERO, 1'b0};
         5'd5:  r = '{SEL_IDX,  SEL_IDX,  SEL_END,  1'b0};
         5'd6:  r = '{SEL_ZERO, SEL_ZERO, SEL_IDX,  1'b1};
         5'd7:  r = '{SEL_ZERO, SEL_END,  SEL_IDX,  1'b1};
         5'd8:  r = '{SEL_END,  SEL_ZERO, SEL_IDX,  1'b1};
         5'd9:  r = '{SEL_END,  SEL_END,  SEL_IDX,  1'b1};
         5'd10: r = '{SEL_ZERO, SEL_IDX,  SEL_ZERO, 1'b1};
         5'd11: r = '{SEL_ZERO, SEL_IDX,  SEL_END,  1'b1};
         5'd12: r = '{SEL_END,  SEL_IDX,  SEL_ZERO, 1'b1};
         5'd13: r = '{SEL_END,  SEL_IDX,  SEL_END,  1'b1};
         5'd14: r = '{SEL_IDX,  SEL_ZERO, SEL_ZERO, 1'b1};
         5'd15: r = '{SEL_IDX,  SEL_ZERO, SEL_END,  1'b1};
         5'd16: r = '{SEL_IDX,  SEL_END,  SEL_ZERO, 1'b1};
         5'd17: r = '{SEL_IDX,  SEL_END,  SEL_END,  1'b1};
         5'd18: r = '{SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0};
         5'd19: r = '{SEL_END,  SEL_ZERO, SEL_ZERO, 1'b0};
         5'd20: r = '{SEL_END,  SEL_END,  SEL_ZERO, 1'b0};
         5'd21: r = '{SEL_ZERO, SEL_END,  SEL_ZERO, 1'b0};
         5'd22: r = '{SEL_ZERO, SEL_ZERO, SEL_END,  1'b0};
         5'd23: r = '{SEL_END,  SEL_ZERO, SEL_END,  1'b0};
         5'd24: r = '{SEL_END,  SEL_END,  SEL_END,  1'b0};
         5'd25: r = '{SEL_ZERO, SEL_END,  SEL_END,  1'b0};
         default: ;
      endcase
      return r;
   endfunction

   // operand slots of each product weight
   function automatic wop_type weight_ops(input logic [4:0] dst);
      wop_type r;
      r = '{W_A0, W_B0};
      case (dst)
         5'd6:  r = '{W_A0, W_B0};
         5'd7:  r = '{W_A0, W_B1};
         5'd8:  r = '{W_A1, W_B0};
         5'd9:  r = '{W_A1, W_B1};
         5'd10: r = '{W_A0, W_C0};
         5'd11: r = '{W_A0, W_C1};
         5'd12: r = '{W_A1, W_C0};
         5'd13: r = '{W_A1, W_C1};
         5'd14: r = '{W_B0, W_C0};
         5'd15: r = '{W_B0, W_C1};
         5'd16: r = '{W_B1, W_C0};
         5'd17: r = '{W_B1, W_C1};
         5'd18: r = '{W_A0B0, W_C0};
         5'd19: r = '{W_A1B0, W_C0};
         5'd20: r = '{W_A1B1, W_C0};
         5'd21: r = '{W_A0B1, W_C0};
         5'd22: r = '{W_A0B0, W_C1};
         5'd23: r = '{W_A1B0, W_C1};
         5'd24: r = '{W_A1B1, W_C1};
         5'd25: r = '{W_A0B1, W_C1};
         default: ;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/transfinite_interp_3d.sv
// Top level: grid store and sequencer for 3-D linear transfinite interpolation.
// A load beat with indices in range is written to the grid store and gives no result;
// loads can follow back to back. A compute beat raises rsp_tvalid after three restoring
// divisions with 21-bit quotients for the weights, 20 weight products on the shared multiplier
// and 26 stored points summed with their weights; a full output slot holds it in the output state.
// A non-interior point skips to the output state. Reset clears control, sets sizes to 32.
module transfinite_interp_3d import tfi_pkg::*; #(
   parameter int MAX_N      = MAX_N_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // idx_x[4:0], idx_y[9:5], idx_z[14:10], coord_x_in[46:15], coord_y_in[78:47],
   // coord_z_in[110:79], zero pad[111]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,   // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // coord_x_out[31:0], coord_y_out[63:32], coord_z_out[95:64]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser,   // status
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   localparam int SW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int LG    = $clog2(MAX_N);
   localparam int AW    = 3 * LG;
   localparam int DEPTH = 1 << AW;
   localparam int PW    = SW + 18;
   localparam int ACCW  = SW + 22;
   localparam int QW    = ACCW - 16;
   localparam int DVW   = 21;
   localparam logic [4:0] DIV_LAST = 5'(DVW - 1);
   localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [QW-1:0] Q_LO = QW'(-(64'sd1 <<< (SW - 1)));
   localparam logic signed [32:0]   L_HI = 33'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [32:0]   L_LO = 33'(-(64'sd1 <<< (SW - 1)));

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DIV    = 11'b00000000010,
      ST_WLATCH = 11'b00000000100,
      ST_WMUL   = 11'b00000001000,
      ST_WSTORE = 11'b00000010000,
      ST_TRD    = 11'b00000100000,
      ST_TMX    = 11'b00001000000,
      ST_TMY    = 11'b00010000000,
      ST_TMZ    = 11'b00100000000,
      ST_TACC   = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [SIZE_W-1:0]       sx_ff, sy_ff, sz_ff;
   logic [IDX_W-1:0]        ix_ff, iy_ff, iz_ff, ix_in, iy_in, iz_in;
   logic [6:0]              ex_ff, ey_ff, ez_ff, ex_in, ey_in, ez_in;
   logic [6:0]              ex_c, ey_c, ez_c;
   logic [1:0]              axis_ff, axis_in;
   logic [4:0]              bit_ff, bit_in;
   logic [4:0]              step_ff, step_in;
   logic [DVW-1:0]          quo_ff, quo_in, quo_n;
   logic [5:0]              rem_ff, rem_in, rem_n;
   logic [6:0]              shifted;
   logic                    ge;
   logic [5:0]              div_d;
   logic [WGT_W-1:0]        wt_ff [N_TERMS];
   logic [4:0]              wsel;
   logic [WGT_W-1:0]        wval;
   logic [WGT_W-1:0]        opnd_ff;
   logic signed [SW:0]      mul_a;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic [PW-1:0]           wsum;
   logic signed [ACCW-1:0]  acc_x_ff, acc_y_ff, acc_z_ff, acc_x_in, acc_y_in, acc_z_in;
   logic signed [ACCW-1:0]  term_v;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    req_acc, is_load, load_ok, interior;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [3*SW-1:0]         ram_wdata, ram_rdata;
   logic signed [SW-1:0]    rd_x, rd_y, rd_z;
   wop_type                 wop;
   term_type                tinf;

   function automatic logic [6:0] end_of(input logic [SIZE_W-1:0] r);
      logic [6:0] n;
      n = {1'b0, r};
      if (n < 7'd3) n = 7'd3;
      else if (n > 7'(MAX_N)) n = 7'(MAX_N);
      return n - 7'd1;
   endfunction

   function automatic logic [LG-1:0] lg_idx(input logic [IDX_W-1:0] idx);
      logic [6:0] t;
      t = {2'b00, idx};
      return t[LG-1:0];
   endfunction

   function automatic logic [LG-1:0] pick(input axsel_type s, input logic [IDX_W-1:0] idx,
                                          input logic [6:0] e);
      logic [LG-1:0] r;
      r = '0;
      case (s)
         SEL_IDX: r = lg_idx(idx);
         SEL_END: r = e[LG-1:0];
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [DVW-1:0] dividend(input logic [IDX_W-1:0] idx,
                                               input logic [6:0] e);
      return {idx, 16'h0000} + DVW'(e[5:1]);
   endfunction

   function automatic logic [SW-1:0] load_sat(input logic [COORD_W-1:0] v);
      logic signed [32:0] s;
      logic [32:0]        r;
      s = 33'($signed(v));
      if (s > L_HI) r = L_HI;
      else if (s < L_LO) r = L_LO;
      else r = s;
      return r[SW-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACCW-1:0] a);
      logic signed [ACCW-1:0] t;
      logic signed [QW-1:0]   q;
      logic signed [SW-1:0]   s;
      t = a + ACCW'(32768);
      q = QW'(t >>> 16);
      if (q > Q_HI) s = Q_HI[SW-1:0];
      else if (q < Q_LO) s = Q_LO[SW-1:0];
      else s = q[SW-1:0];
      return 32'(s);
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_load    = (req_tuser == KIND_LOAD);

   assign ex_c = end_of(sx_ff);
   assign ey_c = end_of(sy_ff);
   assign ez_c = end_of(sz_ff);

   assign load_ok = ({2'b00, req_tdata[4:0]} < 7'(MAX_N)) &&
                    ({2'b00, req_tdata[9:5]} < 7'(MAX_N)) &&
                    ({2'b00, req_tdata[14:10]} < 7'(MAX_N));
   assign interior = (req_tdata[4:0] != '0) && ({2'b00, req_tdata[4:0]} < ex_c) &&
                     (req_tdata[9:5] != '0) && ({2'b00, req_tdata[9:5]} < ey_c) &&
                     (req_tdata[14:10] != '0) && ({2'b00, req_tdata[14:10]} < ez_c);

   // grid store: one word holds z, y, x of a point
   assign ram_we    = req_acc && is_load && load_ok;
   assign ram_waddr = {lg_idx(req_tdata[14:10]), lg_idx(req_tdata[9:5]),
                       lg_idx(req_tdata[4:0])};
   assign ram_wdata = {load_sat(req_tdata[110:79]), load_sat(req_tdata[78:47]),
                       load_sat(req_tdata[46:15])};
   assign tinf      = term_info(step_ff);
   assign ram_raddr = {pick(tinf.sz, iz_ff, ez_ff), pick(tinf.sy, iy_ff, ey_ff),
                       pick(tinf.sx, ix_ff, ex_ff)};

   tfi_ram #(.WIDTH(3 * SW), .DEPTH(DEPTH)) u_tfi_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_x = ram_rdata[SW-1:0];
   assign rd_y = ram_rdata[2*SW-1:SW];
   assign rd_z = ram_rdata[3*SW-1:2*SW];

   // divider step
   always_comb begin
      case (axis_ff)
         2'd0:    div_d = ex_ff[5:0];
         2'd1:    div_d = ey_ff[5:0];
         default: div_d = ez_ff[5:0];
      endcase
      shifted = {rem_ff, quo_ff[DVW-1]};
      ge      = (shifted >= {1'b0, div_d});
      rem_n   = ge ? 6'(shifted - {1'b0, div_d}) : shifted[5:0];
      quo_n   = {quo_ff[DVW-2:0], ge};
   end

   // shared multiplier
   assign wop = weight_ops(step_ff);
   always_comb begin
      case (state_ff)
         ST_WLATCH: wsel = wop.p;
         ST_WMUL:   wsel = wop.q;
         default:   wsel = step_ff;
      endcase
      wval = wt_ff[wsel];
      case (state_ff)
         ST_WMUL: mul_a = $signed((SW + 1)'(opnd_ff));
         ST_TMY:  mul_a = (SW + 1)'(rd_y);
         ST_TMZ:  mul_a = (SW + 1)'(rd_z);
         default: mul_a = (SW + 1)'(rd_x);
      endcase
      prod_in = mul_a * $signed({1'b0, wval});
      wsum    = prod_ff + PW'(32768);
      term_v  = ACCW'(prod_ff);
      if (tinf.neg) term_v = -term_v;
   end

   always_comb begin
      state_in     = state_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      iz_in        = iz_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      ez_in        = ez_ff;
      axis_in      = axis_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_z_in     = acc_z_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && !is_load) begin
               ix_in    = req_tdata[4:0];
               iy_in    = req_tdata[9:5];
               iz_in    = req_tdata[14:10];
               ex_in    = ex_c;
               ey_in    = ey_c;
               ez_in    = ez_c;
               acc_x_in = '0;
               acc_y_in = '0;
               acc_z_in = '0;
               axis_in  = 2'd0;
               bit_in   = '0;
               rem_in   = '0;
               quo_in   = dividend(req_tdata[4:0], ex_c);
               err_in   = interior ? STATUS_OK : STATUS_ERR;
               state_in = interior ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            rem_in = rem_n;
            quo_in = quo_n;
            bit_in = bit_ff + 5'd1;
            if (bit_ff == DIV_LAST) begin
               bit_in  = '0;
               rem_in  = '0;
               axis_in = axis_ff + 2'd1;
               quo_in  = (axis_ff == 2'd0) ? dividend(iy_ff, ey_ff) : dividend(iz_ff, ez_ff);
               if (axis_ff == 2'd2) begin
                  step_in  = W_FIRST_PROD;
                  state_in = ST_WLATCH;
               end
            end
         end
         ST_WLATCH: state_in = ST_WMUL;
         ST_WMUL:   state_in = ST_WSTORE;
         ST_WSTORE: begin
            if (step_ff == W_LAST) begin
               step_in  = '0;
               state_in = ST_TRD;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_WLATCH;
            end
         end
         ST_TRD: state_in = ST_TMX;
         ST_TMX: state_in = ST_TMY;
         ST_TMY: begin
            acc_x_in = acc_x_ff + term_v;
            state_in = ST_TMZ;
         end
         ST_TMZ: begin
            acc_y_in = acc_y_ff + term_v;
            state_in = ST_TACC;
         end
         ST_TACC: begin
            acc_z_in = acc_z_ff + term_v;
            if (step_ff == W_LAST) begin
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_TRD;
            end
         end
         ST_OUT: begin
            // hold until the output slot frees
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {round_sat(acc_z_ff), round_sat(acc_y_ff),
                               round_sat(acc_x_ff)};
               rsp_user_in  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sx_ff        <= SIZE_RESET;
         sy_ff        <= SIZE_RESET;
         sz_ff        <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_SIZE_X: sx_ff <= csr_wdata;
               CSR_SIZE_Y: sy_ff <= csr_wdata;
               CSR_SIZE_Z: sz_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ix_ff       <= ix_in;
      iy_ff       <= iy_in;
      iz_ff       <= iz_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      ez_ff       <= ez_in;
      axis_ff     <= axis_in;
      bit_ff      <= bit_in;
      step_ff     <= step_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      acc_z_ff    <= acc_z_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      prod_ff     <= prod_in;
      if (state_ff == ST_WLATCH) begin
         opnd_ff <= wval;
      end
      // a1 = quotient, a0 = 1 - a1 in Q0.16
      if (state_ff == ST_DIV && bit_ff == DIV_LAST) begin
         wt_ff[5'({axis_ff, 1'b1})] <= quo_n[WGT_W-1:0];
         wt_ff[5'({axis_ff, 1'b0})] <= WGT_W'(0) - quo_n[WGT_W-1:0];
      end
      if (state_ff == ST_WSTORE) begin
         wt_ff[step_ff] <= wsum[31:16];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/tfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/tfi_chk.sv
// Port-level checks of the transfinite interpolation block, bound to its top level.
module tfi_chk import tfi_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // an error result carries zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_ERR) |-> rsp_tdata == '0)
      else $error("error beat with nonzero coordinates");

   // a compute beat keeps the input closed for at least the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_COMPUTE) |=> !req_tready)
      else $error("input ready right after a compute beat");

   // a load beat never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after a load beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind transfinite_interp_3d tfi_chk u_tfi_chk (.*);

>>> tb/tb.sv
// Self-checking bench for the 3-D transfinite interpolation block, with a shadow grid.
module tb import tfi_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_N    = 32;
   localparam int SLOTS     = GRID_N * GRID_N * GRID_N;
   localparam int ITEMS     = 1450;
   localparam int SETTLE    = 300;
   localparam int CALM_FROM = 1250;

   typedef struct {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
      logic        st;
   } point_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_SIZE_X;
   logic [SIZE_W-1:0]     csr_wdata = '0;

   int             grid_val [3][SLOTS];
   bit             loaded [SLOTS];
   logic [5:0]     size_reg [3];
   point_rsp_type  pending_pts [$];

   int  items_sent = 0;
   int  n_loads = 0;
   int  n_interior = 0;
   int  n_edge_err = 0;
   int  n_checked = 0;
   int  n_mismatch = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   int  stall_left = 0;

   transfinite_interp_3d dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic int eff_size(input logic [5:0] r);
      if (r < 3) return 3;
      if (r > GRID_N) return GRID_N;
      return int'(r);
   endfunction

   function automatic int slot(input int i, input int j, input int k);
      return (k * GRID_N + j) * GRID_N + i;
   endfunction

   function automatic longint unsigned frac_mul(input longint unsigned p,
                                                input longint unsigned q);
      return (p * q + 32768) >> 16;
   endfunction

   function automatic longint unsigned axis_weight(input int idx, input int n);
      longint unsigned d;
      d = n - 1;
      return (longint'(idx) * 65536 + d / 2) / d;
   endfunction

   function automatic bit is_interior(input int i, input int j, input int k);
      return i >= 1 && i < eff_size(size_reg[0]) - 1 && j >= 1 && j < eff_size(size_reg[1]) - 1
         && k >= 1 && k < eff_size(size_reg[2]) - 1;
   endfunction

   // axis selector: 0 low face, 1 the point's own index, 2 high face
   function automatic int pick_idx(input int sel, input int idx, input int n);
      return sel == 0 ? 0 : (sel == 1 ? idx : n - 1);
   endfunction

   function automatic point_rsp_type interp_point(input int i, input int j, input int k);
      point_rsp_type r;
      int n [3];
      int p [3];
      int sel [3];
      longint unsigned w1 [3];
      longint unsigned w, aw;
      longint acc [3];
      longint q;
      int nb, a;
      r = '{32'd0, 32'd0, 32'd0, STATUS_ERR};
      if (!is_interior(i, j, k)) return r;
      p = '{i, j, k};
      for (int ax = 0; ax < 3; ax++) begin
         n[ax] = eff_size(size_reg[ax]);
         w1[ax] = axis_weight(p[ax], n[ax]);
      end
      acc = '{0, 0, 0};
      for (int t = 0; t < 27; t++) begin
         sel = '{t % 3, (t / 3) % 3, t / 9};
         if (t == 13) continue;
         nb = 0;
         w = 0;
         for (int ax = 0; ax < 3; ax++) begin
            if (sel[ax] != 1) begin
               aw = sel[ax] == 0 ? 65536 - w1[ax] : w1[ax];
               w = nb == 0 ? aw : frac_mul(w, aw);
               nb++;
            end
         end
         a = slot(pick_idx(sel[0], i, n[0]), pick_idx(sel[1], j, n[1]),
                  pick_idx(sel[2], k, n[2]));
         for (int c = 0; c < 3; c++) begin
            if (nb == 2) acc[c] -= longint'(grid_val[c][a]) * longint'(w);
            else acc[c] += longint'(grid_val[c][a]) * longint'(w);
         end
      end
      for (int c = 0; c < 3; c++) begin
         q = (acc[c] + 32768) >>> 16;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         case (c)
            0: r.cx = q[31:0];
            1: r.cy = q[31:0];
            default: r.cz = q[31:0];
         endcase
      end
      r.st = STATUS_OK;
      return r;
   endfunction

   task automatic send_item(input logic kind, input int i, input int j, input int k,
                            input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
      int gap;
      int a;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, vz, vy, vx, 5'(k), 5'(j), 5'(i)};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      items_sent++;
      if (kind == KIND_LOAD) begin
         a = slot(i, j, k);
         grid_val[0][a] = vx;
         grid_val[1][a] = vy;
         grid_val[2][a] = vz;
         loaded[a] = 1'b1;
         n_loads++;
      end else begin
         pending_pts.push_back(interp_point(i, j, k));
         if (is_interior(i, j, k)) n_interior++;
         else n_edge_err++;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leave the write channel valid; the caller drops it after the last beat
   task automatic write_size(input logic [CSR_ADDR_W-1:0] ra, input logic [5:0] v);
      csr_valid <= 1'b1;
      csr_addr  <= ra;
      csr_wdata <= v;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      case (ra)
         CSR_SIZE_X: size_reg[0] = v;
         CSR_SIZE_Y: size_reg[1] = v;
         default:    size_reg[2] = v;
      endcase
   endtask

   task automatic set_sizes(input logic [5:0] sx, input logic [5:0] sy, input logic [5:0] sz);
      wait_drained();
      write_size(CSR_SIZE_X, sx);
      write_size(CSR_SIZE_Y, sy);
      write_size(CSR_SIZE_Z, sz);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // load the 26 boundary points the interpolation of (i,j,k) reads;
   // pattern 0 fills only unloaded ones with random values, 1 and 2 drive the
   // sum to the positive or negative limit (faces and corners one way, edges the other)
   task automatic prepare_point(input int i, input int j, input int k, input int pattern);
      int sel [3];
      int n [3];
      int nb, a, ii, jj, kk;
      logic [31:0] hi, lo, v;
      for (int ax = 0; ax < 3; ax++) n[ax] = eff_size(size_reg[ax]);
      hi = pattern == 2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      lo = pattern == 2 ? 32'h7FFF_FFFF : 32'h8000_0000;
      for (int t = 0; t < 27; t++) begin
         sel = '{t % 3, (t / 3) % 3, t / 9};
         if (t == 13) continue;
         nb = (sel[0] != 1) + (sel[1] != 1) + (sel[2] != 1);
         ii = pick_idx(sel[0], i, n[0]);
         jj = pick_idx(sel[1], j, n[1]);
         kk = pick_idx(sel[2], k, n[2]);
         a = slot(ii, jj, kk);
         if (pattern == 0 && loaded[a]) continue;
         v = nb == 2 ? lo : hi;
         if (pattern == 0) send_item(KIND_LOAD, ii, jj, kk, rand_coord(), rand_coord(),
                                     rand_coord());
         else send_item(KIND_LOAD, ii, jj, kk, v, v, v);
      end
   endtask

   task automatic interp_at(input int i, input int j, input int k, input int pattern);
      if (is_interior(i, j, k)) prepare_point(i, j, k, pattern);
      send_item(KIND_COMPUTE, i, j, k, $urandom, $urandom, $urandom);
   endtask

   task automatic random_interior();
      interp_at($urandom_range(1, eff_size(size_reg[0]) - 2),
                $urandom_range(1, eff_size(size_reg[1]) - 2),
                $urandom_range(1, eff_size(size_reg[2]) - 2), 0);
   endtask

   task automatic test_reset_sizes();
      interp_at(1, 1, 1, 0);
      interp_at(30, 30, 30, 0);
      interp_at(0, 5, 5, 0);
      interp_at(31, 5, 5, 0);
      interp_at(5, 31, 0, 0);
      wait_drained();
   endtask

   task automatic test_smallest_grid();
      set_sizes(6'd0, 6'd1, 6'd2);
      interp_at(1, 1, 1, 0);
      interp_at(2, 1, 1, 0);
      interp_at(1, 1, 0, 0);
      interp_at(1, 1, 1, 1);
      interp_at(1, 1, 1, 2);
      set_sizes(6'd3, 6'd3, 6'd3);
      interp_at(1, 1, 1, 0);
      wait_drained();
   endtask

   task automatic test_oversized_grid();
      set_sizes(6'd63, 6'd33, 6'd32);
      interp_at(30, 1, 15, 0);
      interp_at(16, 30, 30, 2);
      interp_at(1, 1, 31, 0);
      wait_drained();
   endtask

   // stall the receiver for a long stretch while computes keep coming
   task automatic test_backpressure();
      set_sizes(6'd4, 6'd5, 6'd6);
      hold_req = 1'b1;
      repeat (8) random_interior();
      wait_drained();
   endtask

   task automatic test_random();
      int r;
      logic [5:0] s [3];
      while (items_sent < ITEMS) begin
         for (int ax = 0; ax < 3; ax++) begin
            r = $urandom_range(0, 9);
            s[ax] = r == 0 ? 6'($urandom_range(0, 63)) :
                    r < 3 ? 6'($urandom_range(9, 32)) : 6'($urandom_range(3, 8));
         end
         set_sizes(s[0], s[1], s[2]);
         for (int it = 0; it < 25 && items_sent < ITEMS; it++) begin
            if (items_sent >= CALM_FROM) calm = 1'b1;
            r = $urandom_range(0, 9);
            if (r < 7) random_interior();
            else if (r == 7) send_item(KIND_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       rand_coord());
            else interp_at($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), 0);
         end
      end
      wait_drained();
   endtask

   initial begin
      size_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_smallest_grid();
      test_oversized_grid();
      test_backpressure();
      test_random();
      $display("covered %0d loads, %0d interior and %0d rejected points, %0d results checked",
               n_loads, n_interior, n_edge_err, n_checked);
      if (n_mismatch == 0 && pending_pts.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch, pending_pts.size());
         $display("tb NOT OK");
      end
      $finish;
   end

   // receiver: random stall bursts, one long hold on request, none once calm
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = 1500;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && !reset && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      point_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pts.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result beat %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_pts.pop_front();
            n_checked++;
            if (rsp_tdata[31:0] !== want.cx || rsp_tdata[63:32] !== want.cy
                || rsp_tdata[95:64] !== want.cz || rsp_tuser !== want.st) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: expected x %h y %h z %h st %b, got x %h y %h z %h st %b",
                           want.cx, want.cy, want.cz, want.st, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

endmodule
